### rtl/swq_pkg.sv
package swq_pkg;

	localparam int OP_BITS   = 2;
	localparam int IKEY_BITS = 32;
	localparam int PID_BITS  = 5;
	localparam int ST_BITS   = 2;

	typedef enum logic [OP_BITS-1:0] {
		OP_BLOCK  = 2'd0,
		OP_REMOVE = 2'd1,
		OP_OUT    = 2'd2,
		OP_PEEK   = 2'd3
	} op_t;

	typedef enum logic [ST_BITS-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef struct packed {
		logic [OP_BITS-1:0]   op;
		logic [IKEY_BITS-1:0] key;
		logic [PID_BITS-1:0]  pid;
	} req_t;

	typedef struct packed {
		logic [ST_BITS-1:0]  status;
		logic                pid_valid;
		logic [PID_BITS-1:0] out_pid;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_RD,
		S_DEC,
		S_LNK,
		S_DONE
	} state_t;

endpackage

### rtl/semaphore_wait_queue_table_core.sv
// The result strobe rises after the search, which sweeps the descriptor memory one entry per cycle,
// and then after the read, update and link steps.
// One word at a time; busy stays high through the strobe cycle, so the next word is not
// accepted until the strobe has gone.
// Results are shown for one cycle on done; the receiver cannot stall.
// Reset (arst_n low) frees every descriptor and clears all waiting flags at once.
module semaphore_wait_queue_table_core import swq_pkg::*; #(
	parameter int SLOTS    = 32,
	parameter int KEY_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = IW + 1;

	// valid bits in flops, payload in memories
	logic [SLOTS-1:0] sem_used_q;
	logic [SLOTS-1:0] proc_waiting_q;
	logic [KEY_BITS-1:0] sem_key_mem [SLOTS];
	logic [IW-1:0]       sem_head_mem [SLOTS];
	logic [IW-1:0]       sem_tail_mem [SLOTS];
	logic [KEY_BITS-1:0] proc_key_mem [SLOTS];
	logic [IW-1:0]       proc_next_mem [SLOTS];
	logic [IW-1:0]       proc_prev_mem [SLOTS];

	state_t state_q, state_d;
	op_t op_q;
	logic [KEY_BITS-1:0] key_q;
	logic pid_ok_q;
	logic [IW-1:0] p_q;
	logic [CW-1:0] scan_q;
	logic hit_q, free_ok_q;
	logic [IW-1:0] hit_q_idx, free_q;
	logic [KEY_BITS-1:0] key_rd_s1;
	logic [IW-1:0] head_rd_s1, tail_rd_s1, next_rd_s1, prev_rd_s1;
	logic [KEY_BITS-1:0] pkey_rd_s1;
	logic [IW-1:0] rd_p;
	rsp_t rsp_q;
	rsp_t rsp_n;
	logic done_q;

	logic [IW-1:0] scan_idx;
	assign scan_idx = scan_q[IW-1:0];
	logic [IW-1:0] d_idx;

	// process index of the popped/taken entry
	assign rd_p = (op_q == OP_OUT) ? p_q : head_rd_s1;

	// memory reads, registered
	always_ff @(posedge clk) begin
		key_rd_s1  <= sem_key_mem[scan_idx];
		head_rd_s1 <= sem_head_mem[d_idx];
		tail_rd_s1 <= sem_tail_mem[d_idx];
		pkey_rd_s1 <= proc_key_mem[p_q];
		next_rd_s1 <= proc_next_mem[rd_p];
		prev_rd_s1 <= proc_prev_mem[rd_p];
	end

	// search key: given key, or the waiting key of the process for out
	logic [KEY_BITS-1:0] skey;
	assign skey = (op_q == OP_OUT) ? pkey_rd_s1 : key_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_SRCH;
			S_SRCH: if (scan_q == CW'(SLOTS)) state_d = S_RD;
			S_RD:   state_d = S_DEC;
			S_DEC:  state_d = S_LNK;
			S_LNK:  state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_LNK);
		end
	end

	// request capture and descriptor sweep; key read is registered, so it is checked at the index before scan
	logic srch_chk;
	assign srch_chk = (state_q == S_SRCH) && (scan_q != '0);
	logic [IW-1:0] chk_idx;
	assign chk_idx = IW'(scan_q - CW'(1));
	logic srch_hit;
	assign srch_hit = srch_chk && sem_used_q[chk_idx] && (key_rd_s1 == skey) && !hit_q;

	// a hit on the last swept entry steers the descriptor reads at once
	assign d_idx = srch_hit ? chk_idx : hit_q_idx;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q      <= op_t'(req.op);
			key_q     <= KEY_BITS'(req.key);
			pid_ok_q  <= (32'(req.pid) < SLOTS);
			p_q       <= IW'(req.pid);
			scan_q    <= '0;
			hit_q     <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (state_q == S_SRCH) begin
			scan_q <= scan_q + CW'(1);
			if (srch_chk) begin
				if (srch_hit) begin
					hit_q     <= 1'b1;
					hit_q_idx <= chk_idx;
				end
				if (!sem_used_q[chk_idx] && !free_ok_q) begin
					free_ok_q <= 1'b1;
					free_q    <= chk_idx;
				end
			end
		end
	end

	// decide and write back
	logic [IW-1:0] hp;
	logic is_h, is_t;
	assign hp   = (op_q == OP_OUT) ? p_q : head_rd_s1;
	assign is_h = (head_rd_s1 == hp);
	assign is_t = (tail_rd_s1 == hp);
	logic waiting_p;
	assign waiting_p = pid_ok_q && proc_waiting_q[p_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sem_used_q     <= '0;
			proc_waiting_q <= '0;
		end else if (state_q == S_DEC) begin
			case (op_q)
				OP_BLOCK: if (pid_ok_q && !proc_waiting_q[p_q] && (hit_q || free_ok_q)) begin
					proc_waiting_q[p_q] <= 1'b1;
					if (!hit_q) sem_used_q[free_q] <= 1'b1;
				end
				OP_REMOVE, OP_OUT: if (hit_q && (op_q == OP_REMOVE || waiting_p)) begin
					proc_waiting_q[hp] <= 1'b0;
					if (is_h && is_t) sem_used_q[d_idx] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// response word of the current request
	always_comb begin
		rsp_n = '{status: ST_MISS, pid_valid: 1'b0, out_pid: '0};
		case (op_q)
			OP_BLOCK: begin
				if (!pid_ok_q || proc_waiting_q[p_q]) rsp_n.status = ST_MISS;
				else if (hit_q || free_ok_q) rsp_n.status = ST_OK;
				else rsp_n.status = ST_FULL;
			end
			default: begin
				if (hit_q && (op_q != OP_OUT || waiting_p)) begin
					rsp_n.status    = ST_OK;
					rsp_n.pid_valid = 1'b1;
					rsp_n.out_pid   = PID_BITS'(hp);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DEC) begin
			rsp_q <= rsp_n;
			case (op_q)
				OP_BLOCK: begin
					if (!pid_ok_q || proc_waiting_q[p_q]) ;
					else if (hit_q) begin
						proc_prev_mem[p_q] <= tail_rd_s1;
						sem_tail_mem[d_idx] <= p_q;
						proc_key_mem[p_q] <= key_q;
					end else if (free_ok_q) begin
						sem_key_mem[free_q]  <= key_q;
						sem_head_mem[free_q] <= p_q;
						sem_tail_mem[free_q] <= p_q;
						proc_key_mem[p_q]    <= key_q;
					end
				end
				default: begin
					if (hit_q && (op_q != OP_OUT || waiting_p)) begin
						if (op_q != OP_PEEK) begin
							if (is_h && !is_t) sem_head_mem[d_idx] <= next_rd_s1;
							else if (is_t && !is_h) sem_tail_mem[d_idx] <= prev_rd_s1;
						end
					end
				end
			endcase
		end else if (state_q == S_LNK) begin
			// neighbor links: append, or splice out a middle entry
			if (op_q == OP_BLOCK && rsp_q.status == ST_OK && hit_q)
				proc_next_mem[tail_rd_s1] <= p_q;
			else if ((op_q == OP_OUT) && rsp_q.pid_valid && !is_h && !is_t) begin
				proc_next_mem[prev_rd_s1] <= next_rd_s1;
				proc_prev_mem[next_rd_s1] <= prev_rd_s1;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
